// ===== src/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants for the button press classifier
// Event codes, one-hot press status, result struct and register indexes.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_UNIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME  = 2'd3;

  localparam logic [THR_W-1:0] TICK_UNIT_RST = 16'd10;
  localparam logic [THR_W-1:0] SHORT_MIN_RST = 16'd50;
  localparam logic [THR_W-1:0] LONG_TIME_RST = 16'd1000;

  typedef enum logic [1:0] {
    EV_PRESSED       = 2'd0,
    EV_LONG_PRESSED  = 2'd1,
    EV_RELEASED      = 2'd2,
    EV_LONG_RELEASED = 2'd3
  } event_t;

  // press status, one-hot
  typedef enum logic [2:0] {
    PS_PRESSED      = 3'b001,
    PS_LONG_PRESSED = 3'b010,
    PS_RELEASED     = 3'b100
  } press_t;

  typedef struct packed {
    logic   fire;
    event_t code;
  } evt_res_t;

endpackage

// ===== src/button_debounce_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core: debounced short/long press events
// An accepted tick word is staged in s1; a fired event is registered in out.
// Throughput: one tick word per cycle while the event output drains; an event
// word held by out_stall blocks the staged tick, so the input stalls as well.
// Reset (rst_n low, synchronous): pipeline empty, button released, hold time
// zero, registers at their defaults (disabled, unit 10, short 50, long 1000).
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core
  import bdpc_pkg::*;
#(
  parameter int DEBOUNCE_TICKS = 3,
  parameter int HOLD_WIDTH     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_raw_level,
  // event output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_code,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // mismatch counter must hold DEBOUNCE_TICKS itself for the compare
  localparam int CNT_W = (DEBOUNCE_TICKS < 2) ? 1 : $clog2(DEBOUNCE_TICKS + 1);

  // configuration
  logic             enabled_r;
  logic [THR_W-1:0] tick_unit_r;
  logic [THR_W-1:0] short_min_r;
  logic [THR_W-1:0] long_time_r;

  // tick state
  logic                  deb_r,   deb_nxt;
  logic [CNT_W-1:0]      cnt_r,   cnt_nxt;
  logic [HOLD_WIDTH-1:0] hold_r,  hold_nxt;
  press_t                press_r, press_nxt;
  evt_res_t              res;

  // pipeline
  logic   s1_valid_r;
  logic   s1_raw_r;
  logic   out_valid_r;
  event_t out_code_r;

  logic in_acc;
  logic out_free;
  logic proc;
  logic load_out;

  // out register frees up when empty or drained this edge
  assign out_free = !out_valid_r || !out_stall;
  // the staged tick is evaluated only when its event has somewhere to go
  assign proc     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  // a disabled block drops the tick with no state change
  assign load_out = proc && enabled_r && res.fire;

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      tick_unit_r <= TICK_UNIT_RST;
      short_min_r <= SHORT_MIN_RST;
      long_time_r <= LONG_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:   enabled_r   <= cfg_wdata[0];
        CFG_TICK_UNIT: tick_unit_r <= cfg_wdata[THR_W-1:0];
        CFG_SHORT_MIN: short_min_r <= cfg_wdata[THR_W-1:0];
        CFG_LONG_TIME: long_time_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  bdpc_eval #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
    .HOLD_WIDTH     (HOLD_WIDTH),
    .CNT_W          (CNT_W)
  ) u_eval (
    .raw_level (s1_raw_r),
    .deb       (deb_r),
    .cnt       (cnt_r),
    .hold      (hold_r),
    .press     (press_r),
    .tick_unit (tick_unit_r),
    .short_min (short_min_r),
    .long_time (long_time_r),
    .deb_nxt   (deb_nxt),
    .cnt_nxt   (cnt_nxt),
    .hold_nxt  (hold_nxt),
    .press_nxt (press_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r   <= 1'b0;
      cnt_r   <= '0;
      hold_r  <= '0;
      press_r <= PS_RELEASED;
    end else if (proc && enabled_r) begin
      deb_r   <= deb_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
      press_r <= press_nxt;
    end
  end

  // control of the two pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r <= in_raw_level;
    end
    if (load_out) begin
      out_code_r <= res.code;
    end
  end

  // with the button released the hold time is always cleared
  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !deb_r |-> hold_r == '0)
    else $error("hold time nonzero while released");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(DEBOUNCE_TICKS))
    else $error("debounce counter out of range");

  a_long_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res.code == EV_LONG_RELEASED) |-> press_r == PS_LONG_PRESSED)
    else $error("long release without long press");

  a_rel_state: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (res.code == EV_RELEASED || res.code == EV_LONG_RELEASED))
      |=> (press_r == PS_RELEASED && !deb_r))
    else $error("release event did not clear press state");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in pipeline");

endmodule

// ===== src/bdpc_eval.sv =====
// ----------------------------------------------------------------------------
// bdpc_eval: next-state and event logic for one polling tick
// Debounce counter, saturating hold time and threshold classification.
// ----------------------------------------------------------------------------
module bdpc_eval
  import bdpc_pkg::*;
#(
  parameter int DEBOUNCE_TICKS = 3,
  parameter int HOLD_WIDTH     = 16,
  parameter int CNT_W          = 2
) (
  input  logic                  raw_level,
  input  logic                  deb,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [HOLD_WIDTH-1:0] hold,
  input  press_t                press,
  input  logic [THR_W-1:0]      tick_unit,
  input  logic [THR_W-1:0]      short_min,
  input  logic [THR_W-1:0]      long_time,
  output logic                  deb_nxt,
  output logic [CNT_W-1:0]      cnt_nxt,
  output logic [HOLD_WIDTH-1:0] hold_nxt,
  output press_t                press_nxt,
  output evt_res_t              res
);

  localparam int CMP_W = (HOLD_WIDTH > THR_W) ? HOLD_WIDTH : THR_W;
  localparam int SUM_W = CMP_W + 1;
  localparam logic [SUM_W-1:0] HOLD_MAX =
    {{(SUM_W-HOLD_WIDTH){1'b0}}, {HOLD_WIDTH{1'b1}}};

  logic [CNT_W-1:0]      cnt_inc;
  logic [SUM_W-1:0]      sum;
  logic [HOLD_WIDTH-1:0] hold_sat;
  logic                  long_hit;
  logic                  short_hit;
  logic                  rel_hit;

  assign cnt_inc = cnt + CNT_W'(1);

  always_comb begin
    if (raw_level != deb) begin
      if (cnt_inc >= CNT_W'(DEBOUNCE_TICKS)) begin
        deb_nxt = raw_level;
        cnt_nxt = '0;
      end else begin
        deb_nxt = deb;
        cnt_nxt = cnt_inc;
      end
    end else begin
      deb_nxt = deb;
      cnt_nxt = '0;
    end
  end

  assign sum       = SUM_W'(hold) + SUM_W'(tick_unit);
  assign hold_sat  = (sum > HOLD_MAX) ? {HOLD_WIDTH{1'b1}} : sum[HOLD_WIDTH-1:0];
  assign long_hit  = CMP_W'(hold_sat) >= CMP_W'(long_time);
  assign short_hit = CMP_W'(hold_sat) >= CMP_W'(short_min);
  // release compares the hold time from before this tick
  assign rel_hit   = CMP_W'(hold) >= CMP_W'(short_min);

  always_comb begin
    press_nxt = press;
    res.fire  = 1'b0;
    res.code  = EV_PRESSED;
    if (deb_nxt) begin
      hold_nxt = hold_sat;
      if (long_hit) begin
        if (press != PS_LONG_PRESSED) begin
          press_nxt = PS_LONG_PRESSED;
          res.fire  = 1'b1;
          res.code  = EV_LONG_PRESSED;
        end
      end else if (short_hit) begin
        if (press != PS_PRESSED) begin
          press_nxt = PS_PRESSED;
          res.fire  = 1'b1;
          res.code  = EV_PRESSED;
        end
      end
    end else begin
      hold_nxt  = '0;
      press_nxt = PS_RELEASED;
      res.fire  = rel_hit;
      res.code  = (press == PS_LONG_PRESSED) ? EV_LONG_RELEASED : EV_RELEASED;
    end
  end

endmodule
